// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/fltpw_pkg.sv =====
package fltpw_pkg;

	localparam int VaWidth   = 48;
	localparam int DataWidth = 64;
	localparam int PaWidth   = 63;
	localparam int KindWidth = 2;
	localparam int LvlWidth  = 3;

	typedef logic [KindWidth-1:0] kind_t;
	typedef logic [LvlWidth-1:0]  level_t;

	localparam kind_t KIND_READ  = 2'd0;
	localparam kind_t KIND_DONE  = 2'd1;
	localparam kind_t KIND_ERROR = 2'd2;

	localparam level_t LVL_IDLE = 3'd0;
	localparam level_t LVL_PML4 = 3'd1;
	localparam level_t LVL_PDPT = 3'd2;
	localparam level_t LVL_PD   = 3'd3;
	localparam level_t LVL_PT   = 3'd4;

	localparam int PsBit = 7;

endpackage

// ===== src/four_level_page_table_walker_core.sv =====
// throughput: one word per cycle unless out_ready stalls the output; each accepted word goes into
// the input register, then single-pass walk logic into the output register, with walk state
// updated as each word leaves the input register
// reset: arst_n low clears both valid flags, the walk level, the saved address and
// table_base at once
module four_level_page_table_walker_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic [fltpw_pkg::VaWidth-1:0]       virt_addr,
	input  logic [fltpw_pkg::DataWidth-1:0]     read_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output fltpw_pkg::kind_t                    result_kind,
	output logic [fltpw_pkg::DataWidth-1:0]     mem_addr,
	output logic [fltpw_pkg::PaWidth-1:0]       phys_addr,
	output logic                                large_page,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fltpw_pkg::DataWidth-1:0]     table_base
);
	import fltpw_pkg::*;

	logic                 valid_s1;
	logic                 action_s1;
	logic [VaWidth-1:0]   va_s1;
	logic [DataWidth-1:0] data_s1;

	logic [DataWidth-1:0] table_base_q;
	level_t               walk_level_q;
	logic [VaWidth-1:0]   saved_virtual_q;

	logic                 advance;
	logic                 busy;
	level_t               level_d;
	logic [VaWidth-1:0]   saved_d;
	kind_t                kind_d;
	logic [DataWidth-1:0] mem_d;
	logic [PaWidth-1:0]   phys_d;
	logic                 large_d;

	assign advance   = !out_valid || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign busy      = walk_level_q inside {[LVL_PML4:LVL_PT]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			va_s1     <= virt_addr;
			data_s1   <= read_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base_q <= '0;
		end else if (cfg_valid) begin
			table_base_q <= table_base;
		end
	end

	always_comb begin
		level_d = walk_level_q;
		saved_d = saved_virtual_q;
		kind_d  = KIND_ERROR;
		mem_d   = '0;
		phys_d  = '0;
		large_d = 1'b0;
		if (!action_s1) begin
			if (!busy) begin
				saved_d = va_s1;
				level_d = LVL_PML4;
				kind_d  = KIND_READ;
				mem_d   = {table_base_q[63:12], va_s1[47:39], 3'b000};
			end
		end else if (busy) begin
			case (walk_level_q)
				LVL_PML4: begin
					level_d = LVL_PDPT;
					kind_d  = KIND_READ;
					mem_d   = {1'b0, data_s1[62:12], saved_virtual_q[38:30], 3'b000};
				end
				LVL_PDPT: begin
					level_d = LVL_PD;
					kind_d  = KIND_READ;
					mem_d   = {1'b0, data_s1[62:12], saved_virtual_q[29:21], 3'b000};
				end
				LVL_PD: begin
					if (data_s1[PsBit]) begin
						level_d = LVL_IDLE;
						kind_d  = KIND_DONE;
						phys_d  = {data_s1[62:21], saved_virtual_q[20:0]};
						large_d = 1'b1;
					end else begin
						level_d = LVL_PT;
						kind_d  = KIND_READ;
						mem_d   = {1'b0, data_s1[62:12], saved_virtual_q[20:12], 3'b000};
					end
				end
				default: begin
					level_d = LVL_IDLE;
					kind_d  = KIND_DONE;
					phys_d  = {data_s1[62:12], saved_virtual_q[11:0]};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_level_q    <= LVL_IDLE;
			saved_virtual_q <= '0;
			out_valid       <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
			if (valid_s1) begin
				walk_level_q    <= level_d;
				saved_virtual_q <= saved_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_kind <= kind_d;
			mem_addr    <= mem_d;
			phys_addr   <= phys_d;
			large_page  <= large_d;
		end
	end

endmodule

// ===== src/fltpw_checker.sv =====
`include "assert_macros.svh"

module fltpw_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input fltpw_pkg::kind_t                    result_kind,
	input logic [fltpw_pkg::DataWidth-1:0]     mem_addr,
	input logic [fltpw_pkg::PaWidth-1:0]       phys_addr,
	input logic                                large_page
);
	import fltpw_pkg::*;

	// stalled result word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(result_kind) && $stable(mem_addr) && $stable(phys_addr))

	`ASSERT_SAME(a_kind_legal, clk, arst_n, out_valid,
		result_kind == KIND_READ || result_kind == KIND_DONE || result_kind == KIND_ERROR)

	`ASSERT_SAME(a_mem_zero, clk, arst_n, out_valid && result_kind != KIND_READ, mem_addr == '0)

	`ASSERT_SAME(a_phys_zero, clk, arst_n, out_valid && result_kind != KIND_DONE,
		phys_addr == '0 && !large_page)

	// read request addresses are entry aligned
	`ASSERT_SAME(a_mem_align, clk, arst_n, out_valid && result_kind == KIND_READ,
		mem_addr[2:0] == 3'b000)

endmodule

bind four_level_page_table_walker_core fltpw_checker u_fltpw_checker (.*);
